// ----- hdl/wav_pkg.sv -----
// ----------------------------------------------------------------------------
// wav_pkg
// Shared types, constants and header tag helpers for the WAV header parser.
// ----------------------------------------------------------------------------
package wav_pkg;

  localparam int unsigned RATE_W     = 32;
  localparam int unsigned OFFSET_W   = 6;
  localparam int unsigned PERIOD_W   = 20;
  localparam int unsigned DAC_W      = 10;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

  localparam logic [OFFSET_W-1:0] OFF_RATE_LO  = 6'd24;
  localparam logic [OFFSET_W-1:0] OFF_RATE_HI  = 6'd27;
  localparam logic [OFFSET_W-1:0] OFF_HDR_LAST = 6'd43;

  typedef enum logic [1:0] {
    KIND_PERIOD    = 2'd0,
    KIND_SAMPLE    = 2'd1,
    KIND_TAG_ERR   = 2'd2,
    KIND_ZERO_RATE = 2'd3
  } kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  take;     // an input item is accepted this cycle
    logic  adv;      // step the header offset and collect rate bytes
    logic  clr;      // return offset and rate to their reset values
    logic  emit;     // load the output register
    kind_t kind;
    logic  div_go;   // start the period division
  } wav_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tag_err;
    logic rate_zero;
    logic hdr_end;
    logic last_in;
    logic last_saved;
    logic div_busy;
    logic out_free;
  } wav_stat_t;

  // Expected character at a header offset, zero where no tag byte sits.
  function automatic logic [7:0] tag_expect(input logic [OFFSET_W-1:0] off);
    logic [7:0] want;
    want = 8'h00;
    case (off)
      6'd0:    want = "R";
      6'd1:    want = "I";
      6'd2:    want = "F";
      6'd3:    want = "F";
      6'd8:    want = "W";
      6'd9:    want = "A";
      6'd10:   want = "V";
      6'd11:   want = "E";
      6'd12:   want = "F";
      6'd13:   want = "M";
      6'd14:   want = "T";
      6'd15:   want = " ";
      6'd36:   want = "D";
      6'd37:   want = "A";
      6'd38:   want = "T";
      6'd39:   want = "A";
      default: want = 8'h00;
    endcase
    return want;
  endfunction

  // Letters match in either case; anything else must match exactly.
  function automatic logic tag_match(input logic [7:0] b, input logic [7:0] want);
    logic upper;
    upper = (want >= "A") && (want <= "Z");
    return (b == want) || (upper && (b == (want + 8'd32)));
  endfunction

endpackage

// ----- hdl/wav_in_if.sv -----
// ----------------------------------------------------------------------------
// wav_in_if
// Input channel: one file byte per item, with a flag on the final byte.
// ----------------------------------------------------------------------------
interface wav_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       last_byte;

  modport source(output valid, output file_byte, output last_byte, input ready);
  modport sink(input valid, input file_byte, input last_byte, output ready);
endinterface

// ----- hdl/wav_out_if.sv -----
// ----------------------------------------------------------------------------
// wav_out_if
// Output channel: one result item per handshake.
// ----------------------------------------------------------------------------
interface wav_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [9:0]  dac_value;
  logic [19:0] sample_period;
  logic        end_of_file;

  modport source(output valid, output result_kind, output dac_value,
                 output sample_period, output end_of_file, input ready);
  modport sink(input valid, input result_kind, input dac_value,
               input sample_period, input end_of_file, output ready);
endinterface

// ----- hdl/wav_div.sv -----
// ----------------------------------------------------------------------------
// wav_div
// Restoring divider, one quotient bit per cycle, used for the period division.
// ----------------------------------------------------------------------------
module wav_div
  import wav_pkg::*;
#(
  parameter int unsigned DW = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DW-1:0]     dividend,
  input  logic [RATE_W-1:0] divisor,
  output logic              busy,
  output logic [DW-1:0]     quotient
);

  localparam int unsigned CW = (DW > 1) ? $clog2(DW) : 1;

  logic [CW-1:0]     cnt;
  logic [RATE_W:0]   rem;
  logic [RATE_W-1:0] dvs;
  logic [DW-1:0]     q;
  logic [RATE_W:0]   rem_sh;
  logic              ge;

  assign rem_sh   = {rem[RATE_W-1:0], q[DW-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(DW - 1);
      rem  <= '0;
      dvs  <= divisor;
      q    <= dividend;
    end else if (busy) begin
      rem <= ge ? (rem_sh - {1'b0, dvs}) : rem_sh;
      q   <= {q[DW-2:0], ge};
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/wav_dp.sv -----
// ----------------------------------------------------------------------------
// wav_dp
// Datapath: header offset, rate collection, tag check, period division and
// the output register.
// ----------------------------------------------------------------------------
module wav_dp
  import wav_pkg::*;
#(
  parameter int unsigned TIMER_CLOCK_HZ = 1000000,
  parameter int unsigned TICK_DIVISOR   = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  wav_cmd_t            cmd,
  output wav_stat_t           stat,
  input  logic [7:0]          file_byte,
  input  logic                last_byte,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [1:0]          result_kind,
  output logic [DAC_W-1:0]    dac_value,
  output logic [PERIOD_W-1:0] sample_period,
  output logic                end_of_file
);

  localparam int unsigned DW = $clog2(TIMER_CLOCK_HZ + 1);

  logic [OFFSET_W-1:0] offset;
  logic [RATE_W-1:0]   rate;
  logic                last_saved;
  logic [7:0]          want;
  logic                div_busy;
  logic [DW-1:0]       quotient;
  logic [DW-1:0]       div_dividend;
  logic [31:0]         q_wide;
  logic [PERIOD_W-1:0] period_sat;

  assign want = tag_expect(offset);

  always_comb begin
    stat.tag_err    = (want != 8'h00) && !tag_match(file_byte, want);
    stat.rate_zero  = (offset == OFF_RATE_HI) && (rate[23:0] == 24'd0) &&
                      (file_byte == 8'd0);
    stat.hdr_end    = offset >= OFF_HDR_LAST;
    stat.last_in    = last_byte;
    stat.last_saved = last_saved;
    stat.div_busy   = div_busy;
    stat.out_free   = !out_valid || out_ready;
  end

  // Flooring by the tick divisor first and then by the rate gives the same
  // quotient as dividing by the rate and then by the tick divisor.
  assign div_dividend = DW'(TIMER_CLOCK_HZ / TICK_DIVISOR);

  wav_div #(
    .DW(DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_go),
    .dividend (div_dividend),
    .divisor  (rate),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign q_wide     = 32'(quotient);
  assign period_sat = (q_wide > 32'(PERIOD_MAX)) ? PERIOD_MAX : q_wide[PERIOD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      offset    <= '0;
      rate      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr) begin
        offset <= '0;
        rate   <= '0;
      end else if (cmd.adv) begin
        offset <= offset + 1'b1;
        if (offset inside {[OFF_RATE_LO:OFF_RATE_HI]}) begin
          rate[8*offset[1:0] +: 8] <= file_byte;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      last_saved <= last_byte;
    end
    if (cmd.emit) begin
      result_kind   <= cmd.kind;
      dac_value     <= (cmd.kind == KIND_SAMPLE) ? {file_byte, 2'b00} : '0;
      sample_period <= (cmd.kind == KIND_PERIOD) ? period_sat : '0;
      end_of_file   <= (cmd.kind == KIND_PERIOD) ? last_saved : last_byte;
    end
  end

endmodule

// ----- hdl/wav_ctrl.sv -----
// ----------------------------------------------------------------------------
// wav_ctrl
// Controller: parse phase, input handshake and sequencing of the division.
// ----------------------------------------------------------------------------
module wav_ctrl
  import wav_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  wav_stat_t stat,
  output wav_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_HEADER,
    ST_PLAY,
    ST_SWALLOW,
    ST_DIV_RATE
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;

  always_comb begin
    cmd        = '0;
    cmd.kind   = KIND_PERIOD;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      ST_HEADER, ST_PLAY, ST_SWALLOW: in_ready = stat.out_free;
      default:                        in_ready = 1'b0;
    endcase
    take     = in_valid && in_ready;
    cmd.take = take;

    case (state)
      ST_HEADER: begin
        if (take) begin
          if (stat.tag_err) begin
            cmd.emit   = 1'b1;
            cmd.kind   = KIND_TAG_ERR;
            state_next = ST_SWALLOW;
          end else if (stat.rate_zero) begin
            cmd.emit   = 1'b1;
            cmd.kind   = KIND_ZERO_RATE;
            state_next = ST_SWALLOW;
          end else if (stat.hdr_end) begin
            cmd.div_go = 1'b1;
            state_next = ST_DIV_RATE;
          end else begin
            cmd.adv = 1'b1;
          end
        end
      end
      ST_PLAY: begin
        if (take) begin
          cmd.emit = 1'b1;
          cmd.kind = KIND_SAMPLE;
        end
      end
      ST_SWALLOW: begin
        cmd.take = take;
      end
      ST_DIV_RATE: begin
        if (!stat.div_busy && stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.kind = KIND_PERIOD;
          if (stat.last_saved) begin
            cmd.clr    = 1'b1;
            state_next = ST_HEADER;
          end else begin
            state_next = ST_PLAY;
          end
        end
      end
      default: begin
        state_next = ST_HEADER;
      end
    endcase

    // The final byte re-arms the parser, except at the header end where the
    // period result still has to be computed first.
    if (take && stat.last_in && !cmd.div_go) begin
      cmd.clr    = 1'b1;
      state_next = ST_HEADER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HEADER;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/wav_header_parse_and_play.sv -----
// A sample or error result is loaded into the output register when its byte is
// taken. Throughput: one byte per cycle while the output register is free,
// except the last header byte, which holds the input for one restoring
// division pass of one quotient bit per cycle, until the period result is
// loaded into the output register.
// Reset (synchronous, active high) returns the parser to header checking.
// ----------------------------------------------------------------------------
// wav_header_parse_and_play
// Checks the 44-byte header of 8-bit WAV data, flags a bad tag or zero rate,
// emits the sample period at header end, then one DAC value per sample byte.
// ----------------------------------------------------------------------------
module wav_header_parse_and_play
  import wav_pkg::*;
#(
  parameter int unsigned TIMER_CLOCK_HZ = 1000000,
  parameter int unsigned TICK_DIVISOR   = 1
) (
  input  logic      clk,
  input  logic      rst,
  wav_in_if.sink    byte_in,
  wav_out_if.source result_out
);

  wav_cmd_t  cmd;
  wav_stat_t stat;

  wav_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_in.valid),
    .in_ready (byte_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wav_dp #(
    .TIMER_CLOCK_HZ (TIMER_CLOCK_HZ),
    .TICK_DIVISOR   (TICK_DIVISOR)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .file_byte     (byte_in.file_byte),
    .last_byte     (byte_in.last_byte),
    .out_ready     (result_out.ready),
    .out_valid     (result_out.valid),
    .result_kind   (result_out.result_kind),
    .dac_value     (result_out.dac_value),
    .sample_period (result_out.sample_period),
    .end_of_file   (result_out.end_of_file)
  );

endmodule
